// ===== hw/rtl/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants, types and tables for the vertex rotate/translate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int TRIG_STAGES_DEF = 16;

   localparam int TRIG_FRAC   = 15;
   localparam int TRIG_W      = TRIG_FRAC + 2;
   localparam int CORDIC_W    = 34;
   localparam int PHASE_W     = 33;
   localparam int ATAN_COUNT  = 24;
   localparam int CSR_INDEX_W = 3;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TABLE [ATAN_COUNT] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ANGLE_X  = 3'd0,
      CSR_ANGLE_Y  = 3'd1,
      CSR_ANGLE_Z  = 3'd2,
      CSR_OFFSET_X = 3'd3,
      CSR_OFFSET_Y = 3'd4,
      CSR_OFFSET_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_v;
      logic signed [TRIG_W-1:0] sin_v;
   } trig_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vrt_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// vrt_cordic_cell
// One rotation-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrt_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  wire logic                                clock,
   input  wire logic signed [vrt_pkg::CORDIC_W-1:0] x_in,
   input  wire logic signed [vrt_pkg::CORDIC_W-1:0] y_in,
   input  wire logic signed [vrt_pkg::PHASE_W-1:0]  z_in,
   input  wire logic                                neg_in,
   output logic signed [vrt_pkg::CORDIC_W-1:0]      x_out,
   output logic signed [vrt_pkg::CORDIC_W-1:0]      y_out,
   output logic signed [vrt_pkg::PHASE_W-1:0]       z_out,
   output logic                                     neg_out
);
   import vrt_pkg::*;

   localparam logic signed [PHASE_W-1:0] ATAN =
      signed'({1'b0, ATAN_TABLE[SHIFT]});

   logic signed [CORDIC_W-1:0] x_ff, y_ff;
   logic signed [PHASE_W-1:0]  z_ff;
   logic                       neg_ff;

   always_ff @(posedge clock) begin
      if (z_in >= 0) begin
         x_ff <= x_in - (y_in >>> SHIFT);
         y_ff <= y_in + (x_in >>> SHIFT);
         z_ff <= z_in - ATAN;
      end else begin
         x_ff <= x_in + (y_in >>> SHIFT);
         y_ff <= y_in - (x_in >>> SHIFT);
         z_ff <= z_in + ATAN;
      end
      neg_ff <= neg_in;
   end

   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign z_out   = z_ff;
   assign neg_out = neg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vrt_trig.sv =====
// ----------------------------------------------------------------------------
// vrt_trig
// Free-running CORDIC chain turning a binary angle into cosine and sine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrt_trig #(
   parameter int ANGLE_WIDTH = vrt_pkg::ANGLE_WIDTH_DEF,
   parameter int TRIG_STAGES = vrt_pkg::TRIG_STAGES_DEF
) (
   input  wire logic                   clock,
   input  wire logic [ANGLE_WIDTH-1:0] angle,
   output vrt_pkg::trig_type           trig
);
   import vrt_pkg::*;

   localparam logic signed [PHASE_W-1:0] QUARTER = 33'sh040000000;
   localparam logic signed [PHASE_W-1:0] HALF    = 33'sh080000000;
   localparam logic signed [CORDIC_W-1:0] RND    = 34'sd16384;

   logic signed [CORDIC_W-1:0] xs [TRIG_STAGES+1];
   logic signed [CORDIC_W-1:0] ys [TRIG_STAGES+1];
   logic signed [PHASE_W-1:0]  zs [TRIG_STAGES+1];
   logic                       ns [TRIG_STAGES+1];

   logic [31:0]                phase;
   logic signed [PHASE_W-1:0]  z_wide;
   logic signed [PHASE_W-1:0]  z_in;
   logic                       neg_in;
   logic signed [PHASE_W-1:0]  z_ff;
   logic                       neg_ff;
   logic signed [CORDIC_W-1:0] xf, yf;
   logic signed [CORDIC_W-1:0] xr, yr;
   trig_type                   trig_ff;

   assign phase  = {angle, {(32-ANGLE_WIDTH){1'b0}}};
   assign z_wide = signed'({phase[31], phase});

   always_comb begin
      z_in   = z_wide;
      neg_in = 1'b0;
      if (z_wide >= QUARTER) begin
         z_in   = z_wide - HALF;
         neg_in = 1'b1;
      end else if (z_wide < -QUARTER) begin
         z_in   = z_wide + HALF;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign xs[0] = CORDIC_GAIN;
   assign ys[0] = '0;
   assign zs[0] = z_ff;
   assign ns[0] = neg_ff;

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
      vrt_cordic_cell #(.SHIFT(i)) u_cell (
         .clock   (clock),
         .x_in    (xs[i]),
         .y_in    (ys[i]),
         .z_in    (zs[i]),
         .neg_in  (ns[i]),
         .x_out   (xs[i+1]),
         .y_out   (ys[i+1]),
         .z_out   (zs[i+1]),
         .neg_out (ns[i+1])
      );
   end

   assign xf = ns[TRIG_STAGES] ? -xs[TRIG_STAGES] : xs[TRIG_STAGES];
   assign yf = ns[TRIG_STAGES] ? -ys[TRIG_STAGES] : ys[TRIG_STAGES];
   assign xr = (xf + RND) >>> TRIG_FRAC;
   assign yr = (yf + RND) >>> TRIG_FRAC;

   always_ff @(posedge clock) begin
      trig_ff.cos_v <= xr[TRIG_W-1:0];
      trig_ff.sin_v <= yr[TRIG_W-1:0];
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vrt_rot_cell.sv =====
// ----------------------------------------------------------------------------
// vrt_rot_cell
// Plane rotation a' = a*c + b*s, b' = b*c - a*s; third coordinate passes by.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrt_rot_cell #(
   parameter int COORD_WIDTH = vrt_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          valid_in,
   input  wire logic signed [COORD_WIDTH-1:0] a_in,
   input  wire logic signed [COORD_WIDTH-1:0] b_in,
   input  wire logic signed [COORD_WIDTH-1:0] p_in,
   input  wire vrt_pkg::trig_type             trig,
   output logic                               valid_out,
   output logic signed [COORD_WIDTH-1:0]      a_out,
   output logic signed [COORD_WIDTH-1:0]      b_out,
   output logic signed [COORD_WIDTH-1:0]      p_out
);
   import vrt_pkg::*;

   localparam int PW = COORD_WIDTH + TRIG_W;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HI  = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] LO  = ~HI;
   localparam logic signed [SW-1:0] RND = SW'(1) <<< (TRIG_FRAC - 1);

   logic signed [PW-1:0]          ac_ff, bs_ff, bc_ff, as_ff;
   logic signed [COORD_WIDTH-1:0] p1_ff, a_ff, b_ff, p2_ff;
   logic                          v1_ff, v2_ff;
   logic signed [SW-1:0]          ac_r, bs_r, bc_r, as_r, a_sum, b_sum;
   logic signed [COORD_WIDTH-1:0] a_in_sat, b_in_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ac_ff <= a_in * trig.cos_v;
         bs_ff <= b_in * trig.sin_v;
         bc_ff <= b_in * trig.cos_v;
         as_ff <= a_in * trig.sin_v;
         p1_ff <= p_in;
         a_ff  <= a_in_sat;
         b_ff  <= b_in_sat;
         p2_ff <= p1_ff;
      end
   end

   assign ac_r  = (SW'(ac_ff) + RND) >>> TRIG_FRAC;
   assign bs_r  = (SW'(bs_ff) + RND) >>> TRIG_FRAC;
   assign bc_r  = (SW'(bc_ff) + RND) >>> TRIG_FRAC;
   assign as_r  = (SW'(as_ff) + RND) >>> TRIG_FRAC;
   assign a_sum = ac_r + bs_r;
   assign b_sum = bc_r - as_r;

   always_comb begin
      if (a_sum > HI)      a_in_sat = HI[COORD_WIDTH-1:0];
      else if (a_sum < LO) a_in_sat = LO[COORD_WIDTH-1:0];
      else                 a_in_sat = a_sum[COORD_WIDTH-1:0];
      if (b_sum > HI)      b_in_sat = HI[COORD_WIDTH-1:0];
      else if (b_sum < LO) b_in_sat = LO[COORD_WIDTH-1:0];
      else                 b_in_sat = b_sum[COORD_WIDTH-1:0];
   end

   assign valid_out = v2_ff;
   assign a_out     = a_ff;
   assign b_out     = b_ff;
   assign p_out     = p2_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_rotate_translate.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_translate
// Rotates a vertex about x, then y, then z, and adds a position offset.
//
// req_*: one vertex per transaction (valid/stall). rsp_*: one world-space
// vertex per transaction (valid/stall). csr_*: register writes, index 0-2
// angles, 3-5 offsets; csr_ready is always high.
// From request to response there are two stages in each of three rotation
// cells and one offset/saturation stage. Throughput is one vertex per cycle
// while the response is not stalled and the trig chains are not settling.
// Sine and cosine come from three free-running CORDIC chains of TRIG_STAGES
// cells. After reset and after every register write, requests are stalled
// while the chains settle.
// When rsp_stall holds a response, the whole pipeline holds and req_stall
// rises in the same cycle. Reset empties the pipeline and clears registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_rotate_translate #(
   parameter int COORD_WIDTH = vrt_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = vrt_pkg::ANGLE_WIDTH_DEF,
   parameter int TRIG_STAGES = vrt_pkg::TRIG_STAGES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [COORD_WIDTH-1:0]            rsp_world_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_world_y,
   output logic signed [COORD_WIDTH-1:0]            rsp_world_z,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [vrt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0]
                                                    csr_wdata
);
   import vrt_pkg::*;

   localparam int SETTLE   = TRIG_STAGES + 2;
   localparam int SETTLE_W = $clog2(SETTLE + 1);

   logic [ANGLE_WIDTH-1:0]        ang_x_ff, ang_y_ff, ang_z_ff;
   logic signed [COORD_WIDTH-1:0] off_x_ff, off_y_ff, off_z_ff;
   logic [SETTLE_W-1:0]           settle_ff, settle_in;
   trig_type                      trig_x, trig_y, trig_z;
   logic                          enable, accept, csr_write;

   logic                          v1, v2, v3;
   logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

   logic                          rsp_valid_ff;
   logic signed [COORD_WIDTH-1:0] wx_ff, wy_ff, wz_ff;
   logic signed [COORD_WIDTH:0]   sx, sy, sz;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable || (settle_ff != '0);
   assign accept    = req_valid && !req_stall;

   assign settle_in = csr_write ? SETTLE_W'(SETTLE) :
                      (settle_ff != '0) ? settle_ff - 1'b1 : settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_x_ff  <= '0;
         ang_y_ff  <= '0;
         ang_z_ff  <= '0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         off_z_ff  <= '0;
         settle_ff <= SETTLE_W'(SETTLE);
      end else begin
         settle_ff <= settle_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_ANGLE_X:  ang_x_ff <= csr_wdata[ANGLE_WIDTH-1:0];
               CSR_ANGLE_Y:  ang_y_ff <= csr_wdata[ANGLE_WIDTH-1:0];
               CSR_ANGLE_Z:  ang_z_ff <= csr_wdata[ANGLE_WIDTH-1:0];
               CSR_OFFSET_X: off_x_ff <= csr_wdata[COORD_WIDTH-1:0];
               CSR_OFFSET_Y: off_y_ff <= csr_wdata[COORD_WIDTH-1:0];
               CSR_OFFSET_Z: off_z_ff <= csr_wdata[COORD_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   vrt_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_trig_x (
      .clock (clock), .angle (ang_x_ff), .trig (trig_x));
   vrt_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_trig_y (
      .clock (clock), .angle (ang_y_ff), .trig (trig_y));
   vrt_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_trig_z (
      .clock (clock), .angle (ang_z_ff), .trig (trig_z));

   // about x: (a, b) = (y, z)
   vrt_rot_cell #(.COORD_WIDTH(COORD_WIDTH)) u_rot_x (
      .clock (clock), .reset (reset), .enable (enable), .valid_in (accept),
      .a_in (req_vertex_y), .b_in (req_vertex_z), .p_in (req_vertex_x),
      .trig (trig_x),
      .valid_out (v1), .a_out (y1), .b_out (z1), .p_out (x1));

   // about y: (a, b) = (z, x)
   vrt_rot_cell #(.COORD_WIDTH(COORD_WIDTH)) u_rot_y (
      .clock (clock), .reset (reset), .enable (enable), .valid_in (v1),
      .a_in (z1), .b_in (x1), .p_in (y1),
      .trig (trig_y),
      .valid_out (v2), .a_out (z2), .b_out (x2), .p_out (y2));

   // about z: (a, b) = (x, y)
   vrt_rot_cell #(.COORD_WIDTH(COORD_WIDTH)) u_rot_z (
      .clock (clock), .reset (reset), .enable (enable), .valid_in (v2),
      .a_in (x2), .b_in (y2), .p_in (z2),
      .trig (trig_z),
      .valid_out (v3), .a_out (x3), .b_out (y3), .p_out (z3));

   assign sx = {x3[COORD_WIDTH-1], x3} + {off_x_ff[COORD_WIDTH-1], off_x_ff};
   assign sy = {y3[COORD_WIDTH-1], y3} + {off_y_ff[COORD_WIDTH-1], off_y_ff};
   assign sz = {z3[COORD_WIDTH-1], z3} + {off_z_ff[COORD_WIDTH-1], off_z_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= v3;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         wx_ff <= (sx[COORD_WIDTH] != sx[COORD_WIDTH-1]) ?
                  {sx[COORD_WIDTH], {(COORD_WIDTH-1){~sx[COORD_WIDTH]}}} : sx[COORD_WIDTH-1:0];
         wy_ff <= (sy[COORD_WIDTH] != sy[COORD_WIDTH-1]) ?
                  {sy[COORD_WIDTH], {(COORD_WIDTH-1){~sy[COORD_WIDTH]}}} : sy[COORD_WIDTH-1:0];
         wz_ff <= (sz[COORD_WIDTH] != sz[COORD_WIDTH-1]) ?
                  {sz[COORD_WIDTH], {(COORD_WIDTH-1){~sz[COORD_WIDTH]}}} : sz[COORD_WIDTH-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_world_x = wx_ff;
   assign rsp_world_y = wy_ff;
   assign rsp_world_z = wz_ff;

   a_no_accept_settling: assert property (@(posedge clock) disable iff (reset)
      (settle_ff != '0) |-> !accept)
      else $error("request accepted while trig chains settle");

   a_write_starts_settle: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (settle_ff == SETTLE_W'(SETTLE)))
      else $error("register write did not restart settle count");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |-> enable)
      else $error("request accepted while pipeline held");

   a_held_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(wx_ff)))
      else $error("held response lost");

endmodule

`default_nettype wire
